@@ design/sorm_pkg.sv @@
// Shared types and constants for the segment overlap raster map.
// No dependencies; imported by the top level, the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none
package sorm_pkg;

  localparam int COORD_W = 10;            // end point coordinate width
  localparam int OC_W    = COORD_W + 2;   // signed walk coordinate, covers -1023..2046
  localparam int CNT_W   = 21;            // overlap count width
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // segment class register codes
  localparam logic CLASS_AXIS = 1'b0;
  localparam logic CLASS_DIAG = 1'b1;

  // cell hit counter values
  localparam logic [1:0] HITS_ONE = 2'd1;
  localparam logic [1:0] HITS_TWO = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] overlap_count;
    logic             segment_drawn;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;   // write zero at the clear address and advance it
    logic load;    // capture the incoming segment
    logic setup;   // derive walk range and direction from the segment
    logic step;    // visit the current cell and advance the walk
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;  // clear address is at the last entry
    logic draw;        // segment matches the selected class
    logic walk_last;   // current cell is the last of the segment
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/segment_overlap_raster_map_top.sv @@
// Top level of the segment overlap raster map: controller plus datapath.
// Uses sorm_pkg, sorm_ctrl, sorm_dp.
//
// Each transaction is one line segment; the block marks its cells in a
// GRID_DIM x GRID_DIM map of saturating 2-bit hit counters and answers with the
// number of cells hit at least twice. After reset the map is cleared one entry
// per cycle with busy high; class writes are taken meanwhile. A segment is
// accepted when start is high and busy low. A drawn segment passes through the
// setup, walk, drain and result states; a skipped one goes from setup to
// result. The result strobe comes in the result state; busy falls in the cycle
// after the strobe. The counter RAM serves one cell read-modify-write per
// cycle. out_valid is high for one cycle and the result must be taken then.
`timescale 1ns / 1ps
`default_nettype none
module segment_overlap_raster_map_top
  import sorm_pkg::*;
#(
  parameter int GRID_DIM = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_valid,
  output out_item_t     out_data,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sorm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  sorm_dp #(
    .GRID_DIM(GRID_DIM)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

endmodule
`default_nettype wire

@@ design/sorm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sorm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1048576
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/sorm_dp.sv @@
// Datapath: segment registers, walk counters, cell counter RAM with
// read-modify-write stage, overlap count and class register. Uses sorm_pkg, sorm_ram.
`timescale 1ns / 1ps
`default_nettype none
module sorm_dp
  import sorm_pkg::*;
#(
  parameter int GRID_DIM = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat,
  input  wire in_item_t  in_data,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int GW    = OC_W + 2;
  localparam logic signed [GW-1:0] GRID_S = GW'(GRID_DIM);
  localparam logic [AW-1:0] GRID_A = AW'(GRID_DIM);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  // configuration register
  logic class_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r <= CLASS_AXIS;
    end else if (cfg_we) begin
      class_r <= cfg_wdata;
    end
  end

  // captured segment
  in_item_t seg_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg_r <= in_data;
    end
  end

  // setup decode
  logic               vert, horiz, axis, draw, swap, dec;
  logic [COORD_W-1:0] a_nxt, b_nxt, y1, y2;
  logic               walk_y_nxt, step_on_nxt;
  logic [COORD_W-1:0] oc_base;

  always_comb begin
    vert  = (seg_r.start_x == seg_r.end_x);
    horiz = (seg_r.start_y == seg_r.end_y);
    axis  = vert | horiz;
    draw  = (class_r == CLASS_AXIS) ? axis : !axis;
    swap  = (seg_r.start_x > seg_r.end_x);
    y1    = swap ? seg_r.end_y : seg_r.start_y;
    y2    = swap ? seg_r.start_y : seg_r.end_y;
    dec   = (y1 > y2);
    priority if (vert) begin
      walk_y_nxt  = 1'b1;
      step_on_nxt = 1'b0;
      a_nxt   = (seg_r.start_y < seg_r.end_y) ? seg_r.start_y : seg_r.end_y;
      b_nxt   = (seg_r.start_y < seg_r.end_y) ? seg_r.end_y : seg_r.start_y;
      oc_base = seg_r.start_x;
    end else if (horiz) begin
      walk_y_nxt  = 1'b0;
      step_on_nxt = 1'b0;
      a_nxt   = swap ? seg_r.end_x : seg_r.start_x;
      b_nxt   = swap ? seg_r.start_x : seg_r.end_x;
      oc_base = seg_r.start_y;
    end else begin
      walk_y_nxt  = 1'b0;
      step_on_nxt = 1'b1;
      a_nxt   = swap ? seg_r.end_x : seg_r.start_x;
      b_nxt   = swap ? seg_r.start_x : seg_r.end_x;
      oc_base = y1;
    end
  end

  // walk registers: t runs a..b, oc is the cross coordinate
  logic [COORD_W-1:0]     t_r, b_r;
  logic signed [OC_W-1:0] oc_r;
  logic                   walk_y_r, step_on_r, step_dec_r, drawn_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      t_r        <= a_nxt;
      b_r        <= b_nxt;
      oc_r       <= $signed({2'b00, oc_base});
      walk_y_r   <= walk_y_nxt;
      step_on_r  <= step_on_nxt;
      step_dec_r <= dec;
      drawn_r    <= draw;
    end else if (cmd.step) begin
      t_r <= t_r + 1'b1;
      if (step_on_r) begin
        oc_r <= step_dec_r ? oc_r - OC_W'(1) : oc_r + OC_W'(1);
      end
    end
  end

  // current cell and range check
  logic signed [OC_W-1:0] t_s, cx, cy;
  logic                   in_range;
  logic [AW-1:0]          cell_addr;

  always_comb begin
    t_s = $signed({2'b00, t_r});
    cx  = walk_y_r ? oc_r : t_s;
    cy  = walk_y_r ? t_s : oc_r;
    in_range = (GW'(cx) >= 0) && (GW'(cx) < GRID_S) &&
               (GW'(cy) >= 0) && (GW'(cy) < GRID_S);
    cell_addr = AW'(AW'(unsigned'(cy)) * GRID_A + AW'(unsigned'(cx)));
  end

  // read stage: one cell per step; write-back follows in the next cycle
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic          rd_en;

  assign rd_en = cmd.step & in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_addr_r <= cell_addr;
    end
  end

  // clear sweep address
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // write-back: zero write of the clear sweep, else saturating hit counter update
  logic [1:0]    old_hits;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;

  always_comb begin
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = 2'd0;
    end else begin
      wr_en   = pend_r && (old_hits < HITS_TWO);
      wr_addr = pend_addr_r;
      wr_data = old_hits + 2'd1;
    end
  end

  sorm_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_hits (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(cell_addr),
    .rdata(old_hits)
  );

  // running count of cells that reach two hits
  logic [CNT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (pend_r && (old_hits == HITS_ONE) && (count_r != COUNT_MAX)) begin
      count_r <= count_r + 1'b1;
    end
  end

  // status and result
  always_comb begin
    stat.clear_last = (clr_addr_r == LAST_A);
    stat.draw       = draw;
    stat.walk_last  = (t_r == b_r);
    out_data.overlap_count = count_r;
    out_data.segment_drawn = drawn_r;
  end

endmodule
`default_nettype wire

@@ design/sorm_ctrl.sv @@
// Controller state machine: clear sweep, segment load, walk, result strobe.
// Uses sorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sorm_ctrl
  import sorm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd,
  output logic          busy,
  output logic          out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (stat.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = stat.draw ? ST_WALK : ST_RESULT;
      ST_WALK:   if (stat.walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SETUP:  cmd.setup = 1'b1;
      ST_WALK:   cmd.step = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: out_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire
